[sv/sid_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sid_pkg: shared constants for the signed integer to decimal ASCII converter
// Character codes, string length limit and the default value width.
// ----------------------------------------------------------------------------
package sid_pkg;

	// default width of the signed input value
	localparam int VALUE_BITS_DEF = 16;

	// longest string that leaves the block
	localparam int MAX_CHARS = 7;
	localparam int IDX_W     = $clog2(MAX_CHARS);

	// number base and the character width
	localparam int DIGIT_BASE = 10;
	localparam int CHAR_W     = 7;

	// ASCII codes
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_POINT = 7'h2E;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

endpackage : sid_pkg
`default_nettype wire

[sv/sid_div10.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sid_div10: registered divide-by-ten unit
// Multiplies by a scaled reciprocal, registers the product, then fixes the
// quotient estimate (low by at most one) with one compare and subtract.
// ----------------------------------------------------------------------------
module sid_div10
	import sid_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  go,
	input  wire logic [VALUE_BITS-1:0] dividend,
	output logic                       done,
	output logic [VALUE_BITS-1:0]      quotient,
	output logic [3:0]                 remainder
);

	// floor(2^VALUE_BITS / 10)
	localparam logic [VALUE_BITS-1:0] RECIP =
		VALUE_BITS'((64'd1 << VALUE_BITS) / 64'd10);
	localparam logic [VALUE_BITS-1:0] BASE = VALUE_BITS'(DIGIT_BASE);

	logic                      v_s1;
	logic [2*VALUE_BITS-1:0]   prod_s1;
	logic [VALUE_BITS-1:0]     dvd_s1;
	logic [VALUE_BITS-1:0]     q_est;
	logic [VALUE_BITS-1:0]     r_est;
	logic                      fix;
	logic                      done_q;
	logic [VALUE_BITS-1:0]     quot_q;
	logic [3:0]                rem_q;

	// stage 1: reciprocal product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= go;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			prod_s1 <= (2*VALUE_BITS)'(dividend) * (2*VALUE_BITS)'(RECIP);
			dvd_s1  <= dividend;
		end
	end

	// stage 2: remainder of the estimate, one correction step
	assign q_est = prod_s1[2*VALUE_BITS-1:VALUE_BITS];
	assign r_est = dvd_s1 - (q_est << 3) - (q_est << 1);
	assign fix   = (r_est >= BASE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			quot_q <= q_est + VALUE_BITS'(fix);
			rem_q  <= fix ? 4'(r_est - BASE) : 4'(r_est);
		end
	end

	assign done      = done_q;
	assign quotient  = quot_q;
	assign remainder = rem_q;

endmodule : sid_div10
`default_nettype wire

[sv/signed_int_to_decimal_ascii.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed integer to decimal ASCII string
// Peels decimal digits off the magnitude with a shared divide-by-ten unit,
// stacks them with point, padding zero and sign, then sends the string
// most significant character first.
//
//   channel  | handshake            | words
//   ---------+----------------------+------------------------------------
//   input    | start, busy          | value, point_position
//   output   | strobe (no stall)    | character, last_char
//
// Steps: accept, one pass of the divide unit per decimal digit, a point,
// padding/sign and set up, then one character sent per cycle (1 to 7).
// Zero skips the divide, point, padding and sign steps.
// busy stays high from accept until the last character word is registered.
// Reset clears the sequencer; the output cannot be stalled.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii
	import sid_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic signed [VALUE_BITS-1:0] value,
	input  wire logic [2:0]                   point_position,
	output logic                              strobe,
	output logic [CHAR_W-1:0]                 character,
	output logic                              last_char
);

	localparam int N_W = $clog2(VALUE_BITS + 4);

	// sequencer states
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DIVIDE = 3'd1;
	localparam logic [2:0] S_POINT  = 3'd2;
	localparam logic [2:0] S_PAD    = 3'd3;
	localparam logic [2:0] S_SIGN   = 3'd4;
	localparam logic [2:0] S_SETUP  = 3'd5;
	localparam logic [2:0] S_EMIT   = 3'd6;

	logic [2:0]              state_q;
	logic [N_W-1:0]          n_q;
	logic [N_W-1:0]          digit_q;
	logic                    last_pt_q;
	logic                    neg_q;
	logic [IDX_W-1:0]        emit_idx_q;
	logic                    strobe_q;
	logic [VALUE_BITS-1:0]   mag_q;
	logic [2:0]              pos_q;
	logic [CHAR_W-1:0]       rev_q [MAX_CHARS];
	logic [CHAR_W-1:0]       character_q;
	logic                    last_char_q;

	logic                    accept;
	logic [VALUE_BITS-1:0]   value_u;
	logic [VALUE_BITS-1:0]   mag_in;
	logic                    div_go;
	logic [VALUE_BITS-1:0]   div_dvd;
	logic                    div_done;
	logic [VALUE_BITS-1:0]   div_quot;
	logic [3:0]              div_rem;
	logic                    at_point;
	logic                    pad_ok;
	logic                    push_en;
	logic [CHAR_W-1:0]       push_char;

	assign accept  = start && !busy;
	assign value_u = value;
	assign mag_in  = value_u[VALUE_BITS-1] ? (~value_u + 1'b1) : value_u;

	// point goes after the digit whose index matches the position
	assign at_point = (digit_q == {{(N_W-3){1'b0}}, pos_q});
	assign pad_ok   = last_pt_q &&
		(({1'b0, n_q} + (N_W+1)'(1) + (N_W+1)'(neg_q)) <= (N_W+1)'(MAX_CHARS));

	// shared divide-by-ten unit
	sid_div10 #(
		.VALUE_BITS(VALUE_BITS)
	) u_div10 (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (div_dvd),
		.done     (div_done),
		.quotient (div_quot),
		.remainder(div_rem)
	);

	// character push and divider launch
	always_comb begin
		push_en   = 1'b0;
		push_char = CHAR_ZERO;
		div_go    = 1'b0;
		div_dvd   = mag_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (mag_in == '0) begin
						push_en = 1'b1;
					end else begin
						div_go  = 1'b1;
						div_dvd = mag_in;
					end
				end
			end
			S_DIVIDE: begin
				if (div_done) begin
					push_en   = 1'b1;
					push_char = CHAR_ZERO + {3'b000, div_rem};
					if (!at_point && div_quot != '0) begin
						div_go  = 1'b1;
						div_dvd = div_quot;
					end
				end
			end
			S_POINT: begin
				push_en   = 1'b1;
				push_char = CHAR_POINT;
				div_go    = (mag_q != '0);
			end
			S_PAD: begin
				push_en = pad_ok;
			end
			S_SIGN: begin
				push_en   = neg_q;
				push_char = CHAR_MINUS;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			n_q        <= '0;
			digit_q    <= '0;
			last_pt_q  <= 1'b0;
			neg_q      <= 1'b0;
			emit_idx_q <= '0;
			strobe_q   <= 1'b0;
		end else begin
			strobe_q <= (state_q == S_EMIT);
			if (push_en) begin
				n_q <= n_q + 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						neg_q     <= value_u[VALUE_BITS-1];
						digit_q   <= '0;
						last_pt_q <= 1'b0;
						state_q   <= (mag_in == '0) ? S_SETUP : S_DIVIDE;
					end
				end
				S_DIVIDE: begin
					if (div_done) begin
						digit_q   <= digit_q + 1'b1;
						last_pt_q <= 1'b0;
						if (at_point) begin
							state_q <= S_POINT;
						end else if (div_quot == '0) begin
							state_q <= S_PAD;
						end
					end
				end
				S_POINT: begin
					last_pt_q <= 1'b1;
					state_q   <= (mag_q == '0) ? S_PAD : S_DIVIDE;
				end
				S_PAD: begin
					state_q <= S_SIGN;
				end
				S_SIGN: begin
					state_q <= S_SETUP;
				end
				S_SETUP: begin
					// only the lowest characters are kept
					emit_idx_q <= (n_q > N_W'(MAX_CHARS)) ? IDX_W'(MAX_CHARS - 1)
						: IDX_W'(n_q - 1'b1);
					state_q    <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_idx_q == '0) begin
						n_q     <= '0;
						state_q <= S_IDLE;
					end else begin
						emit_idx_q <= emit_idx_q - 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// data path registers
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q <= point_position;
		end
		if (div_done) begin
			mag_q <= div_quot;
		end
		if (push_en && n_q < N_W'(MAX_CHARS)) begin
			rev_q[n_q[IDX_W-1:0]] <= push_char;
		end
		if (state_q == S_EMIT) begin
			character_q <= rev_q[emit_idx_q];
			last_char_q <= (emit_idx_q == '0);
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign strobe    = strobe_q;
	assign character = character_q;
	assign last_char = last_char_q;

endmodule : signed_int_to_decimal_ascii
`default_nettype wire

[verif/signed_int_to_decimal_ascii_tb.sv]
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_tb: self-checking bench for the decimal converter
// Drives signed numbers and point positions through the start/busy command
// port. A directed table covers zero, the extremes, the point with and without
// its padding zero, and the longest seven-character strings. Random numbers
// follow, spread over all digit counts. Every character word is checked
// against the table text or a behavioral model of the string builder.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_tb;
	import sid_pkg::*;

	localparam int VBITS        = VALUE_BITS_DEF;
	localparam int N_RANDOM     = 440;
	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 40;

	// one expected character word
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} char_word_t;

	// directed row: empty text means the string comes from the model
	typedef struct {
		int          value;
		int unsigned pos;
		string       text;
	} number_row_t;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic signed [VBITS-1:0] value;
	logic [2:0]              point_position;
	logic                    strobe;
	logic [CHAR_W-1:0]       character;
	logic                    last_char;

	char_word_t pending_chars[$];
	int         errors       = 0;
	int         quiet_cycles = 0;

	number_row_t number_rows[] = '{
		'{0,      0, "0"},
		'{0,      4, "0"},
		'{0,      7, "0"},
		'{32767,  7, "32767"},
		'{-32768, 7, "-32768"},
		'{-32768, 0, "-3276.8"},
		'{-32768, 4, "-.32768"},
		'{12345,  4, "0.12345"},
		'{-12345, 4, "-.12345"},
		'{1,      0, "0.1"},
		'{-1,     0, "-0.1"},
		'{10,     0, "1.0"},
		'{99,     1, "0.99"},
		'{-9999,  3, "-0.9999"},
		'{32767,  5, "32767"},
		'{-32767, 6, ""},
		'{5,      3, ""},
		'{100,    1, ""},
		'{4096,   2, ""},
		'{-700,   2, ""},
		'{21845,  1, ""},
		'{-21846, 3, ""}
	};

	signed_int_to_decimal_ascii #(
		.VALUE_BITS(VBITS)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.value         (value),
		.point_position(point_position),
		.strobe        (strobe),
		.character     (character),
		.last_char     (last_char)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// build the string least significant first, then queue it in send order
	function automatic void predict_decimal(logic signed [VBITS-1:0] v, logic [2:0] pos);
		logic [CHAR_W-1:0] rev[$];
		logic              neg;
		longint unsigned   mag;
		int                digit;
		int                count;
		neg   = v[VBITS-1];
		mag   = {{(64-VBITS){1'b0}}, v};
		digit = 0;
		if (neg)
			mag = (64'd1 << VBITS) - mag;
		if (mag == 0) begin
			rev.push_back(CHAR_ZERO);
		end else begin
			while (mag != 0) begin
				rev.push_back(CHAR_ZERO + CHAR_W'(mag % DIGIT_BASE));
				if (digit == pos)
					rev.push_back(CHAR_POINT);
				digit++;
				mag = mag / DIGIT_BASE;
			end
			// leading zero before a bare point, only if it still fits
			if (rev[$] == CHAR_POINT && rev.size() + 1 + neg <= MAX_CHARS)
				rev.push_back(CHAR_ZERO);
			if (neg)
				rev.push_back(CHAR_MINUS);
		end
		// overlong strings keep their low characters
		count = (rev.size() > MAX_CHARS) ? MAX_CHARS : rev.size();
		for (int k = 0; k < count; k++)
			pending_chars.push_back('{ch: rev[count-1-k], last: (k + 1 == count)});
	endfunction

	// queue a string typed in the table
	function automatic void queue_text(string text);
		for (int k = 0; k < text.len(); k++)
			pending_chars.push_back('{ch: CHAR_W'(text[k]), last: (k + 1 == text.len())});
	endfunction

	// random number, mostly chosen by digit count so short strings show up too
	function automatic logic signed [VBITS-1:0] random_number();
		int          ndig;
		int          lo;
		int          hi;
		int          mag;
		int          pick;
		pick = $urandom_range(9);
		if (pick == 0)
			return VBITS'($urandom);
		if (pick == 1) begin
			case ($urandom_range(5))
				0: return VBITS'(-32768);
				1: return VBITS'(32767);
				2: return VBITS'(-32767);
				3: return VBITS'(1);
				4: return VBITS'(-1);
				default: return '0;
			endcase
		end
		ndig = $urandom_range(1, 5);
		lo   = (ndig == 1) ? 0 : 10 ** (ndig - 1);
		hi   = (ndig == 5) ? 32767 : 10 ** ndig - 1;
		mag  = $urandom_range(hi, lo);
		return VBITS'($urandom_range(1) ? -mag : mag);
	endfunction

	// present one word on the command port, optionally after an idle gap
	task automatic send_number(logic signed [VBITS-1:0] v, logic [2:0] pos, string text,
			bit may_idle);
		int gap;
		if (may_idle && $urandom_range(99) < 16) begin
			gap = $urandom_range(1, 12);
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start          <= 1'b1;
		value          <= v;
		point_position <= pos;
		do @(posedge clk); while (busy);
		if (text.len() > 0)
			queue_text(text);
		else
			predict_decimal(v, pos);
		@(negedge clk);
	endtask

	// check each character word against the oldest expectation
	always @(posedge clk) begin
		char_word_t want;
		if (arst_n && strobe) begin
			if (pending_chars.size() == 0) begin
				errors++;
				$display("%0t: unexpected word: expected none, got char %h last %b",
					$time, character, last_char);
			end else begin
				want = pending_chars.pop_front();
				if (character !== want.ch) begin
					errors++;
					$display("%0t: character mismatch: expected %h, got %h",
						$time, want.ch, character);
				end
				if (last_char !== want.last) begin
					errors++;
					$display("%0t: last_char mismatch: expected %b, got %b",
						$time, want.last, last_char);
				end
			end
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || strobe)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("signed_int_to_decimal_ascii_tb: FAIL");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		arst_n         = 1'b0;
		start          = 1'b0;
		value          = '0;
		point_position = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (number_rows[i])
			send_number(VBITS'(number_rows[i].value), 3'(number_rows[i].pos),
				number_rows[i].text, 1'b1);

		// random part; a middle stretch runs back to back
		for (int i = 0; i < N_RANDOM; i++)
			send_number(random_number(), 3'($urandom_range(7)), "",
				!(i >= 200 && i < 330));
		start <= 1'b0;

		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0 && pending_chars.size() == 0)
			$display("signed_int_to_decimal_ascii_tb: PASS");
		else
			$display("signed_int_to_decimal_ascii_tb: FAIL");
		$finish;
	end

endmodule
